FILE: rtl/cst_pkg.sv
// shared types, constants and the sample step table of the spline tessellator
package cst_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COEF,
        ST_EV0,
        ST_EV1,
        ST_EV2
    } cst_state_t;

    localparam logic [1:0] AXIS_LAST = 2'd2;
    localparam logic [4:0] SEG_MIN   = 5'd4;

    // controller to datapath
    typedef struct packed {
        logic       win_we;
        logic       win_fill;
        logic       coef_en;
        logic [1:0] coef_axis;
        logic       final_mode;
        logic       ev0;
        logic       ev1;
        logic       out_load;
        logic       out_last;
        logic [4:0] seg;
    } cst_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } cst_stat_t;

    typedef struct packed {
        logic [14:0] q;
        logic [4:0]  r;
    } cst_step_t;

    // t increment for a segment of seg samples: 65536 = q*seg + r
    function automatic cst_step_t seg_step(input logic [4:0] seg);
        cst_step_t st;
        case (seg)
            5'd5:    st = '{q: 15'd13107, r: 5'd1};
            5'd6:    st = '{q: 15'd10922, r: 5'd4};
            5'd7:    st = '{q: 15'd9362,  r: 5'd2};
            5'd8:    st = '{q: 15'd8192,  r: 5'd0};
            5'd9:    st = '{q: 15'd7281,  r: 5'd7};
            5'd10:   st = '{q: 15'd6553,  r: 5'd6};
            5'd11:   st = '{q: 15'd5957,  r: 5'd9};
            5'd12:   st = '{q: 15'd5461,  r: 5'd4};
            5'd13:   st = '{q: 15'd5041,  r: 5'd3};
            5'd14:   st = '{q: 15'd4681,  r: 5'd2};
            5'd15:   st = '{q: 15'd4369,  r: 5'd1};
            5'd16:   st = '{q: 15'd4096,  r: 5'd0};
            5'd17:   st = '{q: 15'd3855,  r: 5'd1};
            5'd18:   st = '{q: 15'd3640,  r: 5'd16};
            5'd19:   st = '{q: 15'd3449,  r: 5'd5};
            5'd20:   st = '{q: 15'd3276,  r: 5'd16};
            5'd21:   st = '{q: 15'd3120,  r: 5'd16};
            5'd22:   st = '{q: 15'd2978,  r: 5'd20};
            5'd23:   st = '{q: 15'd2849,  r: 5'd9};
            5'd24:   st = '{q: 15'd2730,  r: 5'd16};
            5'd25:   st = '{q: 15'd2621,  r: 5'd11};
            5'd26:   st = '{q: 15'd2520,  r: 5'd16};
            5'd27:   st = '{q: 15'd2427,  r: 5'd7};
            5'd28:   st = '{q: 15'd2340,  r: 5'd16};
            5'd29:   st = '{q: 15'd2259,  r: 5'd25};
            5'd30:   st = '{q: 15'd2184,  r: 5'd16};
            5'd31:   st = '{q: 15'd2114,  r: 5'd2};
            default: st = '{q: 15'd16384, r: 5'd0};
        endcase
        return st;
    endfunction

endpackage

FILE: rtl/cardinal_spline_tessellator_top.sv
// top level of the cardinal spline tessellator
//
// s_ channel: one control point per transaction; tdata holds x, y, z and
// tension, tuser the group, tlast marks the end of the path. Points of other
// groups only matter through tlast. m_ channel: curve samples x, y, z, tlast
// on the final sample that an input point produces. cfg channel: index 0 is
// samples per segment S (below 4 acts as 4), index 1 the selected group.
// Writes are taken in any cycle and are meant for an idle block.
// Each segment first sets up its coefficients one axis at a time in ST_COEF,
// then each sample passes ST_EV0, ST_EV1 and ST_EV2 through the horner lanes
// (one multiplier per axis, used three times). A middle point emits S samples,
// a closing point up to 2S+1; the input is held off until the point's last
// sample is loaded. Points that emit nothing do not hold off the input.
// A single output register holds a sample; while the receiver stalls the
// sequencer waits in its last step and no new point is taken until the
// point's last sample is in the output register.
// Reset clears the point count, the output valid and sets S=12, group 0.
module cardinal_spline_tessellator_top #(
    parameter int COORD_BITS = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_index,
    input  logic [4:0] cfg_data,
    input  logic s_tvalid,
    output logic s_tready,
    // point_x, point_y, point_z, point_tension, zero fill
    input  logic [((3*COORD_BITS+8+7)/8)*8-1:0] s_tdata,
    // point_group
    input  logic [2:0] s_tuser,
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    // sample_x, sample_y, sample_z, zero fill
    output logic [((3*COORD_BITS+7)/8)*8-1:0] m_tdata,
    output logic m_tlast
);
    import cst_pkg::*;

    localparam int MW = ((3*COORD_BITS+7)/8)*8;

    cst_cmd_t  cmd;
    cst_stat_t stat;
    logic signed [COORD_BITS-1:0] sx, sy, sz;

    cst_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_group   (s_tuser),
        .s_last    (s_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

    cst_dp #(.COORD_BITS(COORD_BITS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_x       (s_tdata[COORD_BITS-1:0]),
        .in_y       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_z       (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .in_tension (s_tdata[3*COORD_BITS+7:3*COORD_BITS]),
        .out_x      (sx),
        .out_y      (sy),
        .out_z      (sz),
        .out_last   (m_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

    assign m_tdata = MW'({sz, sy, sx});

endmodule

FILE: rtl/cst_ctrl.sv
// controller: configuration registers, point count and the emission sequencer
module cst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [4:0]        cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [2:0]        s_group,
    input  logic              s_last,
    output cst_pkg::cst_cmd_t cmd,
    input  cst_pkg::cst_stat_t stat
);
    import cst_pkg::*;

    localparam logic CFG_SPS = 1'b0;
    localparam logic CFG_GRP = 1'b1;

    cst_state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [5:0] k_reg, k_next;
    logic [1:0] axis_reg, axis_next;
    logic       final_pend_reg, final_pend_next;
    logic       mode_final_reg, mode_final_next;
    logic [4:0] spc_reg;
    logic [2:0] grp_reg;

    logic       accept, match, do_mid, do_final, at_end;
    logic [1:0] cnt_after;
    logic [4:0] seg;
    logic [5:0] kend;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign match     = (s_group == grp_reg);
    assign seg       = (spc_reg < SEG_MIN) ? SEG_MIN : spc_reg;
    assign kend      = mode_final_reg ? {1'b0, seg} : ({1'b0, seg} - 6'd1);
    assign at_end    = (k_reg == kend);
    assign cnt_after = (match && cnt_reg != 2'd3) ? cnt_reg + 2'd1 : cnt_reg;
    assign do_mid    = match && (cnt_reg >= 2'd2);
    assign do_final  = s_last && (cnt_after >= 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spc_reg <= 5'd12;
            grp_reg <= 3'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SPS: spc_reg <= cfg_data;
                CFG_GRP: grp_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= 2'd0;
            k_reg          <= 6'd0;
            axis_reg       <= 2'd0;
            final_pend_reg <= 1'b0;
            mode_final_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            k_reg          <= k_next;
            axis_reg       <= axis_next;
            final_pend_reg <= final_pend_next;
            mode_final_reg <= mode_final_next;
        end
    end

    // next state
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        axis_next       = axis_reg;
        final_pend_next = final_pend_reg;
        mode_final_next = mode_final_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next  = s_last ? 2'd0 : cnt_after;
                    k_next    = 6'd0;
                    axis_next = 2'd0;
                    if (do_mid) begin
                        state_next      = ST_COEF;
                        mode_final_next = 1'b0;
                        final_pend_next = do_final;
                    end else if (do_final) begin
                        state_next      = ST_COEF;
                        mode_final_next = 1'b1;
                        final_pend_next = 1'b0;
                    end
                end
            end
            ST_COEF: begin
                if (axis_reg == AXIS_LAST) begin
                    axis_next  = 2'd0;
                    state_next = ST_EV0;
                end else begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_EV0: state_next = ST_EV1;
            ST_EV1: state_next = ST_EV2;
            ST_EV2: begin
                if (stat.out_free) begin
                    if (!at_end) begin
                        k_next     = k_reg + 6'd1;
                        state_next = ST_EV0;
                    end else if (final_pend_reg) begin
                        final_pend_next = 1'b0;
                        mode_final_next = 1'b1;
                        k_next          = 6'd0;
                        axis_next       = 2'd0;
                        state_next      = ST_COEF;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.seg        = seg;
        cmd.final_mode = mode_final_reg;
        cmd.coef_axis  = axis_reg;
        cmd.win_fill   = (cnt_reg == 2'd0);
        cmd.out_last   = at_end && !final_pend_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.win_we = accept && match;
            end
            ST_COEF: cmd.coef_en = 1'b1;
            ST_EV0:  cmd.ev0 = 1'b1;
            ST_EV1:  cmd.ev1 = 1'b1;
            ST_EV2:  cmd.out_load = stat.out_free;
            default: ;
        endcase
    end

endmodule

FILE: rtl/cst_dp.sv
// datapath: point window, coefficients, parameter stepping and horner lanes
module cst_dp #(
    parameter int COORD_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cst_pkg::cst_cmd_t            cmd,
    output cst_pkg::cst_stat_t           stat,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic signed [COORD_BITS-1:0] in_z,
    input  logic [7:0]                   in_tension,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z,
    output logic                         out_last,
    output logic                         out_valid,
    input  logic                         out_ready
);
    import cst_pkg::*;

    localparam int CW = COORD_BITS + 12;   // coefficient width
    localparam int SW = CW + 2;            // horner partial width
    localparam int PW = SW + 18;           // product width
    localparam int RW = PW - 24;
    localparam logic signed [RW-1:0] HI = RW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] LO = -HI - RW'(1);

    logic signed [COORD_BITS-1:0] win_reg [4][3];
    logic [7:0]                   ten_reg [4];
    logic signed [CW-1:0] ca_reg [3];
    logic signed [CW-1:0] cb_reg [3];
    logic signed [CW-1:0] cc_reg [3];
    logic signed [CW-1:0] cd_reg [3];
    logic signed [SW-1:0] s1_reg [3];
    logic signed [SW-1:0] s2_reg [3];
    logic signed [COORD_BITS-1:0] res_reg [3];
    logic [16:0] t_reg;
    logic [4:0]  rem_reg;
    logic        valid_reg, last_reg;

    logic [COORD_BITS-1:0] in_c [3];
    assign in_c[0] = in_x;
    assign in_c[1] = in_y;
    assign in_c[2] = in_z;

    assign stat.out_free = !valid_reg || out_ready;

    // window shift register, newest in slot 3
    always_ff @(posedge aclk) begin
        if (cmd.win_we) begin
            if (cmd.win_fill) begin
                for (int s = 0; s < 4; s++) begin
                    for (int ax = 0; ax < 3; ax++) win_reg[s][ax] <= in_c[ax];
                    ten_reg[s] <= in_tension;
                end
            end else begin
                for (int s = 0; s < 3; s++) begin
                    for (int ax = 0; ax < 3; ax++) win_reg[s][ax] <= win_reg[s+1][ax];
                    ten_reg[s] <= ten_reg[s+1];
                end
                for (int ax = 0; ax < 3; ax++) win_reg[3][ax] <= in_c[ax];
                ten_reg[3] <= in_tension;
            end
        end
    end

    // coefficients for one axis a cycle
    logic [7:0]           t_raw;
    logic signed [9:0]    tn;
    logic signed [CW-1:0] p0, p1, p2, p3, m0, m1, m2, m3;
    logic [1:0]           ax_sel;

    always_comb begin
        ax_sel = cmd.coef_axis;
        t_raw  = cmd.final_mode ? ten_reg[2] : ten_reg[1];
        tn     = (t_raw == 8'd0) ? 10'sd128 : $signed({2'b00, t_raw});
        if (cmd.final_mode) begin
            p0 = CW'(win_reg[1][ax_sel]);
            p1 = CW'(win_reg[2][ax_sel]);
            p2 = CW'(win_reg[3][ax_sel]);
            p3 = CW'(win_reg[3][ax_sel]);
        end else begin
            p0 = CW'(win_reg[0][ax_sel]);
            p1 = CW'(win_reg[1][ax_sel]);
            p2 = CW'(win_reg[2][ax_sel]);
            p3 = CW'(win_reg[3][ax_sel]);
        end
        m0 = CW'(tn) * p0;
        m1 = CW'(tn) * p1;
        m2 = CW'(tn) * p2;
        m3 = CW'(tn) * p3;
    end

    always_ff @(posedge aclk) begin
        if (cmd.coef_en) begin
            ca_reg[ax_sel] <= m2 + m3 - m0 - m1 + ((p1 - p2) <<< 9);
            cb_reg[ax_sel] <= (m0 <<< 1) + m1 - (m2 <<< 1) - m3
                              + ((p2 - p1) <<< 9) + ((p2 - p1) <<< 8);
            cc_reg[ax_sel] <= m2 - m0;
            cd_reg[ax_sel] <= p1 <<< 8;
        end
    end

    // t = floor(k*65536/seg), stepped by quotient and remainder
    cst_step_t st;
    logic [5:0] rem_sum;
    assign st      = seg_step(cmd.seg);
    assign rem_sum = {1'b0, rem_reg} + {1'b0, st.r};

    always_ff @(posedge aclk) begin
        if (cmd.coef_en) begin
            t_reg   <= 17'd0;
            rem_reg <= 5'd0;
        end else if (cmd.out_load) begin
            if (rem_sum >= {1'b0, cmd.seg}) begin
                rem_reg <= 5'(rem_sum - {1'b0, cmd.seg});
                t_reg   <= t_reg + 17'(st.q) + 17'd1;
            end else begin
                rem_reg <= rem_sum[4:0];
                t_reg   <= t_reg + 17'(st.q);
            end
        end
    end

    // one horner lane per axis, one multiply per cycle
    logic signed [17:0] t_s;
    assign t_s = $signed({1'b0, t_reg});

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic signed [SW-1:0] opnd;
        logic signed [PW-1:0] prod, prod_sh, s3, rnd;
        logic signed [RW-1:0] r;

        always_comb begin
            if (cmd.ev0)      opnd = SW'(ca_reg[l]);
            else if (cmd.ev1) opnd = s1_reg[l];
            else              opnd = s2_reg[l];
            prod    = PW'(opnd) * PW'(t_s);
            prod_sh = prod >>> 16;
            s3      = prod + (PW'(cd_reg[l]) <<< 16);
            rnd     = (s3 + (PW'(1) <<< 23)) >>> 24;
            r       = RW'(rnd);
        end

        always_ff @(posedge aclk) begin
            if (cmd.ev0) s1_reg[l] <= SW'(prod_sh) + SW'(cb_reg[l]);
            if (cmd.ev1) s2_reg[l] <= SW'(prod_sh) + SW'(cc_reg[l]);
            if (cmd.out_load) begin
                if (r > HI)      res_reg[l] <= HI[COORD_BITS-1:0];
                else if (r < LO) res_reg[l] <= LO[COORD_BITS-1:0];
                else             res_reg[l] <= r[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
        if (cmd.out_load) last_reg <= cmd.out_last;
    end

    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign out_last  = last_reg;
    assign out_valid = valid_reg;

endmodule

FILE: rtl/cst_checker.sv
// port-level checker for the spline tessellator and its bind
module cst_checker #(
    parameter int COORD_BITS = 24
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((3*COORD_BITS+7)/8)*8-1:0] m_tdata,
    input logic m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled sample changed");

    // more samples of the same point follow, so no point is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken inside a point's samples");

    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("sample valid after reset");

    a_rst_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("not ready after reset");

endmodule

bind cardinal_spline_tessellator_top cst_checker #(.COORD_BITS(COORD_BITS)) u_chk (.*);

FILE: tb/cst_checker.sv
// checker for the spline tessellator: predicts curve samples and compares each m_ transaction
module cst_scoreboard #(
    parameter int COORD_BITS = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_valid,
    input  logic cfg_ready,
    input  logic cfg_index,
    input  logic [4:0] cfg_data,
    input  logic s_tvalid,
    input  logic s_tready,
    input  logic [((3*COORD_BITS+8+7)/8)*8-1:0] s_tdata,
    input  logic [2:0] s_tuser,
    input  logic s_tlast,
    input  logic m_tvalid,
    input  logic m_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0] m_tdata,
    input  logic m_tlast,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_SEGS  = 0;
    localparam int CFG_GROUP = 1;

    typedef struct {
        logic [COORD_BITS-1:0] x, y, z;
        logic                  last;
    } sample_t;

    sample_t sample_q[$];
    logic [COORD_BITS-1:0] win_c[4][3];
    logic [7:0]            win_t[4];
    int                    pts_taken;
    logic [4:0]            segs_reg;
    logic [2:0]            group_reg;

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic logic [COORD_BITS-1:0] curve_axis(longint p0, longint p1,
            longint p2, longint p3, longint tn, longint t);
        longint a, b, c, d, s, r, hi, lo;
        a = -tn*p0 + (512-tn)*p1 + (tn-512)*p2 + tn*p3;
        b = 2*tn*p0 + (tn-768)*p1 + (768-2*tn)*p2 - tn*p3;
        c = -tn*p0 + tn*p2;
        d = p1*256;
        hi = (longint'(1) <<< (COORD_BITS-1)) - 1;
        lo = -hi - 1;
        s = floor_shr(a*t + b*65536, 16);
        s = floor_shr(s*t + c*65536, 16);
        s = s*t + d*65536;
        r = floor_shr(s + 8388608, 24);
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return r[COORD_BITS-1:0];
    endfunction

    task automatic push_segment(int i0, int i1, int i2, int i3, int kend, int segs);
        longint tn;
        longint t;
        sample_t smp;
        logic [COORD_BITS-1:0] v[3];
        tn = win_t[i1];
        if (tn == 0) tn = 128;
        for (int k = 0; k <= kend; k++) begin
            t = (longint'(k) * 65536) / segs;
            for (int ax = 0; ax < 3; ax++)
                v[ax] = curve_axis(longint'($signed(win_c[i0][ax])),
                    longint'($signed(win_c[i1][ax])), longint'($signed(win_c[i2][ax])),
                    longint'($signed(win_c[i3][ax])), tn, t);
            smp.x = v[0];
            smp.y = v[1];
            smp.z = v[2];
            smp.last = 1'b0;
            sample_q = {sample_q, smp};
        end
    endtask

    task automatic take_point();
        int segs;
        int n_prev;
        logic [COORD_BITS-1:0] c[3];
        sample_t tail;
        segs = segs_reg < 4 ? 4 : segs_reg;
        n_prev = sample_q.size();
        for (int ax = 0; ax < 3; ax++) c[ax] = s_tdata[ax*COORD_BITS +: COORD_BITS];
        if (s_tuser == group_reg) begin
            if (pts_taken == 0) begin
                for (int s = 0; s < 4; s++) begin
                    win_c[s] = c;
                    win_t[s] = s_tdata[3*COORD_BITS +: 8];
                end
            end else begin
                for (int s = 0; s < 3; s++) begin
                    win_c[s] = win_c[s+1];
                    win_t[s] = win_t[s+1];
                end
                win_c[3] = c;
                win_t[3] = s_tdata[3*COORD_BITS +: 8];
            end
            if (pts_taken >= 2) push_segment(0, 1, 2, 3, segs-1, segs);
            if (pts_taken < 3) pts_taken++;
        end
        if (s_tlast) begin
            if (pts_taken >= 2) push_segment(1, 2, 3, 3, segs, segs);
            pts_taken = 0;
        end
        if (sample_q.size() > n_prev) begin
            tail = sample_q.pop_back();
            tail.last = 1'b1;
            sample_q = {sample_q, tail};
        end
    endtask

    task automatic check_sample();
        sample_t exp_s;
        if (sample_q.size() == 0) begin
            $error("unexpected sample transaction x=%h", m_tdata[COORD_BITS-1:0]);
            fail_count++;
            return;
        end
        exp_s = sample_q.pop_front();
        if (m_tdata[0 +: COORD_BITS] !== exp_s.x) begin
            $error("sample_x expected %h actual %h", exp_s.x, m_tdata[0 +: COORD_BITS]);
            fail_count++;
        end
        if (m_tdata[COORD_BITS +: COORD_BITS] !== exp_s.y) begin
            $error("sample_y expected %h actual %h", exp_s.y,
                   m_tdata[COORD_BITS +: COORD_BITS]);
            fail_count++;
        end
        if (m_tdata[2*COORD_BITS +: COORD_BITS] !== exp_s.z) begin
            $error("sample_z expected %h actual %h", exp_s.z,
                   m_tdata[2*COORD_BITS +: COORD_BITS]);
            fail_count++;
        end
        if (m_tlast !== exp_s.last) begin
            $error("last_sample expected %b actual %b", exp_s.last, m_tlast);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            pts_taken = 0;
            segs_reg  = 5'd12;
            group_reg = 3'd0;
            for (int s = 0; s < 4; s++) begin
                win_t[s] = '0;
                for (int ax = 0; ax < 3; ax++) win_c[s][ax] = '0;
            end
        end else begin
            if (m_tvalid && m_tready) check_sample();
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SEGS) segs_reg = cfg_data;
                else if (cfg_index == CFG_GROUP) group_reg = cfg_data[2:0];
            end
            if (s_tvalid && s_tready) take_point();
        end
        pending = sample_q.size();
    end
endmodule

FILE: tb/tb.sv
// testbench top: drives control points and register writes into the spline tessellator
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 24;
    localparam int DW = ((3*CB+8+7)/8)*8;
    localparam int MW = ((3*CB+7)/8)*8;
    localparam logic CFG_SEGS  = 1'b0;
    localparam logic CFG_GROUP = 1'b1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [4:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MW-1:0] m_tdata;
    logic m_tlast;
    int fail_count;
    int pending;
    logic calm = 1'b0;
    logic [2:0] cur_group = '0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    cardinal_spline_tessellator_top #(.COORD_BITS(CB)) dut (.*);

    cst_scoreboard #(.COORD_BITS(CB)) u_checker (.*);

    // receiver stalls at random except during calm stretches
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= calm || ($urandom_range(99) >= 24);
    end

    task automatic write_reg(logic idx, logic [4:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // waits out the last expected sample, then the longest possible busy tail
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (250) @(negedge aclk);
    endtask

    // valid stays up after a transaction so points can follow back to back
    task automatic send_point(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z,
                              logic [7:0] tn, logic [2:0] grp, logic lst);
        while (!calm && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= DW'({tn, z, y, x});
        s_tuser  <= grp;
        s_tlast  <= lst;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(5))
            0: return {1'b0, {(CB-1){1'b1}}};
            1: return {1'b1, {(CB-1){1'b0}}};
            2: return CB'($urandom_range(2000)) - CB'(1000);
            default: return CB'($urandom);
        endcase
    endfunction

    task automatic rand_point(logic lst);
        logic [2:0] grp;
        grp = ($urandom_range(99) < 80) ? cur_group : 3'($urandom);
        send_point(rand_coord(), rand_coord(), rand_coord(), 8'($urandom), grp, lst);
    endtask

    localparam logic [CB-1:0] PMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] PMIN = {1'b1, {(CB-1){1'b0}}};

    initial begin
        int plen;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: lowest S and group, then highest S and group
        write_reg(CFG_SEGS, 5'd0);
        write_reg(CFG_GROUP, 5'd0);
        send_point(PMAX, PMIN, '0, 8'd0, 3'd0, 1'b1);
        send_point(PMAX, PMIN, 24'd256, 8'd0, 3'd0, 1'b0);
        send_point(PMIN, PMAX, 24'd1, 8'd255, 3'd0, 1'b0);
        send_point(PMAX, PMAX, PMIN, 8'd1, 3'd5, 1'b0);
        send_point(PMAX, PMIN, PMAX, 8'd128, 3'd0, 1'b0);
        send_point(PMIN, PMIN, PMAX, 8'd200, 3'd0, 1'b0);
        send_point('0, '0, '0, 8'd64, 3'd7, 1'b1);
        drain();
        write_reg(CFG_SEGS, 5'd31);
        write_reg(CFG_GROUP, 5'd7);
        cur_group = 3'd7;
        send_point(24'h000100, 24'hFFFF00, 24'h0, 8'd0, 3'd7, 1'b0);
        send_point(24'h001000, 24'h002000, 24'h7FFFFF, 8'd255, 3'd7, 1'b0);
        send_point(24'hFFF000, 24'h800000, 24'h000010, 8'd90, 3'd7, 1'b0);
        send_point(24'h123456, 24'hABCDEF, 24'h55AA55, 8'd10, 3'd7, 1'b1);
        send_point(24'h000001, 24'h000002, 24'h000003, 8'd1, 3'd7, 1'b0);
        send_point(24'h000004, 24'h000005, 24'h000006, 8'd2, 3'd7, 1'b1);
        drain();

        // random paths under several settings
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph == 3);
            write_reg(CFG_SEGS, (ph % 3 == 0) ? 5'(4 + $urandom_range(4)) :
                                (ph == 5) ? 5'd31 : 5'($urandom_range(3, 20)));
            cur_group = 3'($urandom);
            write_reg(CFG_GROUP, {2'b00, cur_group});
            for (int p = 0; p < 7; p++) begin
                plen = $urandom_range(0, 7);
                for (int i = 0; i < plen; i++) rand_point(1'b0);
                rand_point($urandom_range(9) != 0);
            end
            drain();
        end

        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #40ms;
        $display("tb: failure");
        $finish;
    end
endmodule

FILE: files.f
rtl/cst_pkg.sv
rtl/cst_ctrl.sv
rtl/cst_dp.sv
rtl/cardinal_spline_tessellator_top.sv
rtl/cst_checker.sv
tb/cst_checker.sv
tb/tb.sv
